FILE: hw/rtl/s256h_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s256h_pkg
// shared types, round constants and the sha-256 bit functions
// ----------------------------------------------------------------------------
package s256h_pkg;

	// eight working / chaining words
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
		logic [31:0] f;
		logic [31:0] g;
		logic [31:0] h;
	} s256h_work_t;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_PAD   = 4'b0010,
		ST_ROUND = 4'b0100,
		ST_ADD   = 4'b1000
	} s256h_state_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam s256h_work_t INIT_H = '{
		a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
		e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/s256h_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s256h_round
// one compression round plus the next message schedule word
// ----------------------------------------------------------------------------
module s256h_round
	import s256h_pkg::*;
(
	input  s256h_work_t  work,
	input  logic [31:0]  k_word,
	input  logic [511:0] window,
	output s256h_work_t  work_next,
	output logic [31:0]  w_next
);

	logic [31:0] w_t;
	logic [31:0] t1;
	logic [31:0] t2;

	// window word j holds w[t+j], word 0 at the top
	assign w_t = window[511:480];

	assign t1 = work.h + big_sigma1(work.e) + ((work.e & work.f) ^ (~work.e & work.g))
		+ k_word + w_t;
	assign t2 = big_sigma0(work.a)
		+ ((work.a & work.b) ^ (work.a & work.c) ^ (work.b & work.c));

	always_comb begin
		work_next.h = work.g;
		work_next.g = work.f;
		work_next.f = work.e;
		work_next.e = work.d + t1;
		work_next.d = work.c;
		work_next.c = work.b;
		work_next.b = work.a;
		work_next.a = t1 + t2;
	end

	// w[t+16] from w[t+14], w[t+9], w[t+1], w[t]
	assign w_next = small_sigma1(window[63:32]) + window[223:192]
		+ small_sigma0(window[479:448]) + w_t;

endmodule
`default_nettype wire

FILE: hw/rtl/sha256_stream_hasher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// byte-serial sha-256: gathers bytes into a block, compresses, pads, digests
// ----------------------------------------------------------------------------
// a byte request is taken only while idle; the 64th byte of a block starts the
// 64 rounds and then the chaining add on the single shared round unit, busy meanwhile
// an end request pads one byte per cycle up to the block end, then compresses;
// done pulses in the cycle after the last chaining add and the digest holds after
// the receiver cannot stall: done is a one-cycle strobe, busy low when idle
// arst_n clears the sequencer, counts and loads the initial hash values
// ----------------------------------------------------------------------------
module sha256_stream_hasher
	import s256h_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        message_end,
	output logic        done,
	output logic [63:0] digest_bits_255_192,
	output logic [63:0] digest_bits_191_128,
	output logic [63:0] digest_bits_127_64,
	output logic [63:0] digest_bits_63_0
);

	s256h_state_t state_q;
	s256h_work_t  chain_q;      // chaining words
	s256h_work_t  work_q;       // round working words
	s256h_work_t  work_nxt;
	s256h_work_t  sum;          // chain plus work after round 63
	s256h_work_t  digest_q;
	logic [511:0] win_q;        // block buffer, doubles as schedule window
	logic [31:0]  w_new;
	logic [5:0]   fill_q;
	logic [63:0]  bitcnt_q;
	logic [5:0]   rnd_q;
	logic         end_q;        // message is closing, padding pending
	logic         last_q;       // current compression is the final one
	logic         mark_q;       // 0x80 already appended
	logic         len_q;        // inside the length bytes
	logic         done_q;

	logic         accept;
	logic         absorb;
	logic         in_len;
	logic         wrap;
	logic [7:0]   pad_byte;
	logic [7:0]   abs_byte;
	logic [2:0]   lb_sel;

	assign accept = start && (state_q == ST_IDLE);

	// length phase starts once the mark is in and the fill hits byte 56
	assign in_len = len_q || (mark_q && (fill_q == LEN_POS));
	// length bytes go out most significant first
	assign lb_sel = ~fill_q[2:0];

	always_comb begin
		if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (in_len) begin
			pad_byte = bitcnt_q[{lb_sel, 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// a byte enters the buffer from a request or from the padding walk
	assign absorb   = (accept && byte_present) || (state_q == ST_PAD);
	assign abs_byte = (state_q == ST_PAD) ? pad_byte : data_byte;
	assign wrap     = absorb && (&fill_q);

	s256h_round u_round (
		.work      (work_q),
		.k_word    (ROUND_K[rnd_q]),
		.window    (win_q),
		.work_next (work_nxt),
		.w_next    (w_new)
	);

	always_comb begin
		sum.a = chain_q.a + work_q.a;
		sum.b = chain_q.b + work_q.b;
		sum.c = chain_q.c + work_q.c;
		sum.d = chain_q.d + work_q.d;
		sum.e = chain_q.e + work_q.e;
		sum.f = chain_q.f + work_q.f;
		sum.g = chain_q.g + work_q.g;
		sum.h = chain_q.h + work_q.h;
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			chain_q  <= INIT_H;
			fill_q   <= '0;
			bitcnt_q <= '0;
			rnd_q    <= '0;
			end_q    <= 1'b0;
			last_q   <= 1'b0;
			mark_q   <= 1'b0;
			len_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (absorb) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					mark_q <= 1'b0;
					len_q  <= 1'b0;
					if (start) begin
						if (byte_present) begin
							bitcnt_q <= bitcnt_q + 64'd8;
						end
						if (wrap) begin
							// block full: compress first, pad afterwards if ending
							end_q   <= message_end;
							last_q  <= 1'b0;
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end else if (message_end) begin
							end_q   <= 1'b1;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					mark_q <= 1'b1;
					len_q  <= in_len;
					if (wrap) begin
						last_q  <= in_len;
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (&rnd_q) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (last_q) begin
						// digest out, back to the initial state
						chain_q  <= INIT_H;
						bitcnt_q <= '0;
						end_q    <= 1'b0;
						last_q   <= 1'b0;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						chain_q <= sum;
						state_q <= end_q ? ST_PAD : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (absorb) begin
			win_q <= {win_q[503:0], abs_byte};
		end else if (state_q == ST_ROUND) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (wrap) begin
			work_q <= chain_q;
		end else if (state_q == ST_ROUND) begin
			work_q <= work_nxt;
		end
		if ((state_q == ST_ADD) && last_q) begin
			digest_q <= sum;
		end
	end

	assign busy                = (state_q != ST_IDLE);
	assign done                = done_q;
	assign digest_bits_255_192 = {digest_q.a, digest_q.b};
	assign digest_bits_191_128 = {digest_q.c, digest_q.d};
	assign digest_bits_127_64  = {digest_q.e, digest_q.f};
	assign digest_bits_63_0    = {digest_q.g, digest_q.h};

	// a digest strobe leaves the block idle with cleared counts
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE) && (fill_q == 6'd0) && (bitcnt_q == 64'd0))
		else $error("digest strobe without clean idle state");

	// the last round is always followed by the chaining add
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && (&rnd_q) |=> (state_q == ST_ADD))
		else $error("round 63 not followed by chaining add");

	// a filled block always starts a compression at round 0
	assert property (@(posedge clk) disable iff (!arst_n)
		wrap |=> (state_q == ST_ROUND) && (rnd_q == 6'd0) && (fill_q == 6'd0))
		else $error("full block did not start compression");

	// the final compression only begins after the length bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && last_q |-> end_q && len_q)
		else $error("final compression without length bytes");

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// streaming sha-256 hasher: queued byte requests, digest prediction, checking
// ----------------------------------------------------------------------------
// a queue of requests is built up front: a few hand-picked messages, then
// random messages whose lengths lean on the padding edges. a clocked driver
// issues them with random gaps, a clocked monitor compares every done strobe
// against the digest worked out when the closing request was taken.
// ----------------------------------------------------------------------------
module tb
	import s256h_pkg::*;
();

	// one request as it sits in the stimulus queue
	typedef struct {
		logic [7:0]  data_byte;
		logic        byte_present;
		logic        message_end;
		int unsigned idle_gap;   // cycles to hold off before this request
		bit          wait_drain; // hold until every digest is back
	} hash_req_t;

	typedef struct {
		logic [63:0] w01;
		logic [63:0] w23;
		logic [63:0] w45;
		logic [63:0] w67;
	} digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        byte_present = 1'b0;
	logic        message_end = 1'b0;
	wire         busy;
	wire         done;
	wire  [63:0] digest_bits_255_192;
	wire  [63:0] digest_bits_191_128;
	wire  [63:0] digest_bits_127_64;
	wire  [63:0] digest_bits_63_0;

	hash_req_t pending_req_q[$];
	digest_t   expected_digest_q[$];
	hash_req_t live_req;
	int        gap_left = -1;   // -1: gap of the head request not loaded yet
	int        error_count = 0;
	int        req_count = 0;
	int        msg_count = 0;

	// hash state mirrored by the predictor
	logic [31:0] chain_h [8];
	logic [7:0]  blk_buf [64];
	logic [5:0]  blk_fill;
	logic [63:0] msg_bits;

	sha256_stream_hasher DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.data_byte           (data_byte),
		.byte_present        (byte_present),
		.message_end         (message_end),
		.done                (done),
		.digest_bits_255_192 (digest_bits_255_192),
		.digest_bits_191_128 (digest_bits_191_128),
		.digest_bits_127_64  (digest_bits_127_64),
		.digest_bits_63_0    (digest_bits_63_0)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// digest predictor
	// ------------------------------------------------------------------------
	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void sha_restart();
		chain_h[0] = INIT_H.a;
		chain_h[1] = INIT_H.b;
		chain_h[2] = INIT_H.c;
		chain_h[3] = INIT_H.d;
		chain_h[4] = INIT_H.e;
		chain_h[5] = INIT_H.f;
		chain_h[6] = INIT_H.g;
		chain_h[7] = INIT_H.h;
		blk_fill = '0;
		msg_bits = '0;
	endfunction

	// 64 rounds over the full block buffer, folded into the chaining words
	function automatic void sha_compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
		for (i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
		e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
		for (i = 0; i < 64; i++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
		chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
	endfunction

	function automatic void sha_absorb(input logic [7:0] b);
		blk_buf[blk_fill] = b;
		blk_fill = blk_fill + 6'd1;
		if (blk_fill == 6'd0)
			sha_compress();
	endfunction

	// apply one accepted request; a closing request queues its digest
	function automatic void sha_take_request(input hash_req_t r);
		logic [63:0] len_bits;
		digest_t dg;
		int i;
		if (r.byte_present) begin
			sha_absorb(r.data_byte);
			msg_bits = msg_bits + 64'd8;
		end
		if (r.message_end) begin
			len_bits = msg_bits;
			sha_absorb(PAD_MARK);
			while (blk_fill != LEN_POS)
				sha_absorb(8'h00);
			for (i = 0; i < 8; i++)
				sha_absorb(len_bits[63 - 8*i -: 8]);
			dg.w01 = {chain_h[0], chain_h[1]};
			dg.w23 = {chain_h[2], chain_h[3]};
			dg.w45 = {chain_h[4], chain_h[5]};
			dg.w67 = {chain_h[6], chain_h[7]};
			expected_digest_q.push_back(dg);
			sha_restart();
		end
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	// mostly back-to-back or short gaps, now and then a long one
	function automatic int unsigned pick_gap(input bit burst);
		int unsigned r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic void queue_req(input logic [7:0] db, input logic bp, input logic me,
		input int unsigned gap, input bit drain);
		hash_req_t r;
		r.data_byte = db;
		r.byte_present = bp;
		r.message_end = me;
		r.idle_gap = gap;
		r.wait_drain = drain;
		pending_req_q.push_back(r);
		if (bp || me)
			req_count++;
		if (me)
			msg_count++;
	endfunction

	// one well-formed message with random content and a few ignored requests
	function automatic void queue_message(input int len, input bit force_drain);
		bit burst, end_alone, drain;
		int i;
		burst = ($urandom_range(0, 3) == 0);
		end_alone = (len == 0) || ($urandom_range(0, 2) == 0);
		drain = force_drain || ($urandom_range(0, 11) == 0);
		for (i = 0; i < len; i++) begin
			// empty request: no byte, no end
			if ($urandom_range(0, 9) == 0) begin
				queue_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, pick_gap(burst), drain);
				drain = 1'b0;
			end
			queue_req(8'($urandom_range(0, 255)), 1'b1, !end_alone && (i == len - 1),
				pick_gap(burst), drain);
			drain = 1'b0;
		end
		if (end_alone)
			queue_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, pick_gap(burst), drain);
	endfunction

	// ------------------------------------------------------------------------
	// mismatch reporting
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("%0t mismatch: %s got %h want %h", $time, what, got, want);
		error_count++;
	endtask

	// ------------------------------------------------------------------------
	// driver: start held until taken, then the next request after its gap
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : drive_proc
		logic start_nxt;
		if (arst_n) begin
			start_nxt = start;
			// request taken at this edge
			if (start && !busy) begin
				sha_take_request(live_req);
				start_nxt = 1'b0;
			end
			if (!start_nxt && pending_req_q.size() > 0) begin
				if (gap_left < 0)
					gap_left = pending_req_q[0].idle_gap;
				if (gap_left > 0) begin
					gap_left--;
				end else if (!pending_req_q[0].wait_drain ||
					(expected_digest_q.size() == 0 && !busy)) begin
					live_req = pending_req_q.pop_front();
					gap_left = -1;
					start_nxt = 1'b1;
					data_byte <= live_req.data_byte;
					byte_present <= live_req.byte_present;
					message_end <= live_req.message_end;
				end
			end
			start <= start_nxt;
		end
	end

	// ------------------------------------------------------------------------
	// monitor: every done strobe must match the oldest predicted digest
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch_proc
		digest_t want;
		if (arst_n && done) begin
			if (expected_digest_q.size() == 0) begin
				report_mismatch("digest with no message closed", digest_bits_255_192, '0);
			end else begin
				want = expected_digest_q.pop_front();
				if (digest_bits_255_192 !== want.w01)
					report_mismatch("digest_bits_255_192", digest_bits_255_192, want.w01);
				if (digest_bits_191_128 !== want.w23)
					report_mismatch("digest_bits_191_128", digest_bits_191_128, want.w23);
				if (digest_bits_127_64 !== want.w45)
					report_mismatch("digest_bits_127_64", digest_bits_127_64, want.w45);
				if (digest_bits_63_0 !== want.w67)
					report_mismatch("digest_bits_63_0", digest_bits_63_0, want.w67);
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus, reset and end of run
	// ------------------------------------------------------------------------
	initial begin : stim_proc
		int edge_len [12];
		int len;
		sha_restart();

		// empty message straight after reset
		queue_req(8'h3c, 1'b0, 1'b1, 0, 1'b0);
		// single byte with end, both byte extremes
		queue_req(8'h00, 1'b1, 1'b1, 0, 1'b0);
		queue_req(8'hff, 1'b1, 1'b1, 2, 1'b0);
		// empty requests, bytes, end on its own
		queue_req(8'ha5, 1'b0, 1'b0, 0, 1'b0);
		queue_req(8'h61, 1'b1, 1'b0, 0, 1'b0);
		queue_req(8'h5a, 1'b0, 1'b0, 1, 1'b0);
		queue_req(8'h62, 1'b1, 1'b0, 0, 1'b0);
		queue_req(8'h63, 1'b1, 1'b0, 0, 1'b0);
		queue_req(8'hff, 1'b0, 1'b1, 0, 1'b0);
		// empty message right after a digest
		queue_req(8'h00, 1'b0, 1'b1, 0, 1'b0);
		// pad byte value as data, then end with a byte
		queue_req(8'h80, 1'b1, 1'b0, 0, 1'b0);
		queue_req(8'h7f, 1'b1, 1'b1, 0, 1'b0);
		// two empty messages back to back
		queue_req(8'h00, 1'b0, 1'b1, 0, 1'b0);
		queue_req(8'hff, 1'b0, 1'b1, 0, 1'b0);

		// lengths around the length field and block boundaries
		edge_len = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
		queue_message(56, 1'b1);
		while (req_count < 1250 || msg_count < 40) begin
			case ($urandom_range(0, 9))
				0, 1, 2: len = edge_len[$urandom_range(0, 11)];
				default: len = $urandom_range(0, 24);
			endcase
			queue_message(len, 1'b0);
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// everything issued and taken
		while (pending_req_q.size() != 0 || start)
			@(negedge clk);
		// every digest back
		while (expected_digest_q.size() != 0)
			@(negedge clk);
		// room for a stray strobe after the last digest
		repeat (200) @(negedge clk);

		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin : watchdog_proc
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sha256_stream_hasher.f
hw/rtl/s256h_pkg.sv
hw/rtl/s256h_round.sv
hw/rtl/sha256_stream_hasher.sv
test/tb.sv
